// ===== sv/huffman_code_builder_assert.svh =====
// ----------------------------------------------------------------------------
// huffman_code_builder assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_CODE_BUILDER_ASSERT_SVH
`define HUFFMAN_CODE_BUILDER_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define HCB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define HCB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/hcb_pkg.sv =====
// ----------------------------------------------------------------------------
// hcb_pkg
// Types and fixed widths shared by the Huffman code builder modules.
// ----------------------------------------------------------------------------
package hcb_pkg;

  localparam int WEIGHT_W   = 16;
  localparam int NODE_W     = 19;
  localparam int SYM_FLD_W  = 3;
  localparam int CODE_W     = 5;
  localparam int CODE_IDX_W = 3;
  localparam int CODE_LEN_W = 3;

  typedef struct packed {
    logic [SYM_FLD_W-1:0] symbol;
    logic [WEIGHT_W-1:0]  weight;
    logic                 load_last;
  } item_t;

  typedef struct packed {
    logic [SYM_FLD_W-1:0]  out_symbol;
    logic [CODE_W-1:0]     code_bits;
    logic [CODE_LEN_W-1:0] code_length;
    logic                  last_code;
  } result_t;

  typedef struct packed {
    logic load;
    logic init;
    logic scan;
    logic merge;
    logic step;
    logic emit;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic scan_end;
    logic build_last;
    logic at_root;
    logic last_sym;
  } status_t;

endpackage

// ===== sv/hcb_ctrl.sv =====
// ----------------------------------------------------------------------------
// hcb_ctrl
// Sequencer: weight load, node init, min-pair scans, merges, code walks.
// ----------------------------------------------------------------------------
module hcb_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           load_last,
  output logic           busy,
  output hcb_pkg::cmd_t  cmd,
  input  hcb_pkg::status_t status
);
  import hcb_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_INIT  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_MERGE = 5'b01000,
    ST_WALK  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.load = start;
        if (start && load_last) begin
          state_next = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd.init   = 1'b1;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_end) begin
          state_next = ST_MERGE;
        end
      end
      ST_MERGE: begin
        cmd.merge  = 1'b1;
        state_next = status.build_last ? ST_WALK : ST_SCAN;
      end
      ST_WALK: begin
        if (status.at_root) begin
          cmd.emit = 1'b1;
          if (status.last_sym) begin
            cmd.clear  = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

`include "huffman_code_builder_assert.svh"

  `HCB_ASSERT_NEXT(a_last_starts_build, start && !busy && load_last, state == ST_INIT, "last beat did not start build")
  `HCB_ASSERT_SAME(a_clear_on_final, cmd.clear, cmd.emit && status.last_sym, "weights cleared before final code")
  `HCB_ASSERT_NEXT(a_build_to_walk, state == ST_MERGE && status.build_last, state == ST_WALK, "final merge did not start walk")

endmodule

// ===== sv/hcb_datapath.sv =====
// ----------------------------------------------------------------------------
// hcb_datapath
// Weight store, node table, min-pair scan unit, merge and code walk logic.
// ----------------------------------------------------------------------------
module hcb_datapath #(
  parameter int NUM_SYMBOLS = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  hcb_pkg::item_t    item,
  input  hcb_pkg::cmd_t     cmd,
  output hcb_pkg::status_t  status,
  output logic              strobe,
  output hcb_pkg::result_t  result
);
  import hcb_pkg::*;

  localparam int NUM_NODES = 2 * NUM_SYMBOLS - 1;
  localparam int IDX_W     = $clog2(NUM_NODES);
  localparam int SYM_W     = $clog2(NUM_SYMBOLS);
  localparam int LEN_W     = $clog2(NUM_SYMBOLS);
  localparam logic [IDX_W-1:0] ROOT      = IDX_W'(NUM_NODES - 1);
  localparam logic [IDX_W-1:0] FIRST_INT = IDX_W'(NUM_SYMBOLS);
  localparam logic [SYM_W-1:0] LAST_SYM  = SYM_W'(NUM_SYMBOLS - 1);

  logic [WEIGHT_W-1:0]  leaf_weight [NUM_SYMBOLS];
  logic [NODE_W-1:0]    node_weight [NUM_NODES];
  logic [NUM_NODES-1:0] node_live;
  logic [IDX_W-1:0]     node_parent [NUM_NODES];
  logic [NUM_NODES-1:0] node_side;

  logic [IDX_W-1:0]  k;
  logic [IDX_W-1:0]  scan_idx;
  logic [IDX_W-1:0]  best_idx;
  logic [IDX_W-1:0]  sec_idx;
  logic [NODE_W-1:0] best_w;
  logic [NODE_W-1:0] sec_w;
  logic              best_vld;
  logic              sec_vld;
  logic [SYM_W-1:0]  sym;
  logic [IDX_W-1:0]  node;
  logic [LEN_W-1:0]  len;
  logic [CODE_W-1:0] code;

  logic [NODE_W-1:0] scan_w;
  logic              scan_live;
  logic              take_best;
  logic              take_sec;
  logic              load_ok;

  assign scan_w    = node_weight[scan_idx];
  assign scan_live = node_live[scan_idx];
  assign take_best = scan_live && (!best_vld || (scan_w < best_w));
  assign take_sec  = scan_live && !take_best && (!sec_vld || (scan_w < sec_w));
  assign load_ok   = int'(item.symbol) < NUM_SYMBOLS;

  assign status.scan_end   = (scan_idx == (k - IDX_W'(1)));
  assign status.build_last = (k == ROOT);
  assign status.at_root    = (node == ROOT);
  assign status.last_sym   = (sym == LAST_SYM);

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int i = 0; i < NUM_SYMBOLS; i++) begin
        leaf_weight[i] <= '0;
      end
    end else if (cmd.load && load_ok) begin
      leaf_weight[SYM_W'(item.symbol)] <= item.weight;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      for (int i = 0; i < NUM_SYMBOLS; i++) begin
        node_weight[i] <= NODE_W'(leaf_weight[i]);
        node_live[i]   <= 1'b1;
      end
      for (int i = NUM_SYMBOLS; i < NUM_NODES; i++) begin
        node_weight[i] <= '0;
        node_live[i]   <= 1'b0;
      end
      k        <= FIRST_INT;
      scan_idx <= '0;
      best_vld <= 1'b0;
      sec_vld  <= 1'b0;
    end else if (cmd.scan) begin
      if (take_best) begin
        best_idx <= scan_idx;
        best_w   <= scan_w;
        best_vld <= 1'b1;
        sec_idx  <= best_idx;
        sec_w    <= best_w;
        sec_vld  <= best_vld;
      end else if (take_sec) begin
        sec_idx <= scan_idx;
        sec_w   <= scan_w;
        sec_vld <= 1'b1;
      end
      scan_idx <= scan_idx + IDX_W'(1);
    end else if (cmd.merge) begin
      node_live[best_idx]   <= 1'b0;
      node_live[sec_idx]    <= 1'b0;
      node_live[k]          <= 1'b1;
      node_parent[best_idx] <= k;
      node_parent[sec_idx]  <= k;
      node_side[best_idx]   <= 1'b0;
      node_side[sec_idx]    <= 1'b1;
      node_weight[k]        <= best_w + sec_w;
      k        <= k + IDX_W'(1);
      scan_idx <= '0;
      best_vld <= 1'b0;
      sec_vld  <= 1'b0;
      sym      <= '0;
      node     <= '0;
      len      <= '0;
      code     <= '0;
    end else if (cmd.step) begin
      if (int'(len) < CODE_W) begin
        code[CODE_IDX_W'(len)] <= node_side[node];
      end
      len  <= len + LEN_W'(1);
      node <= node_parent[node];
    end else if (cmd.emit) begin
      sym  <= sym + SYM_W'(1);
      node <= IDX_W'(sym) + IDX_W'(1);
      len  <= '0;
      code <= '0;
    end
  end

  // result register, one beat per symbol
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.out_symbol  <= SYM_FLD_W'(sym);
      result.code_bits   <= code;
      result.code_length <= CODE_LEN_W'(len);
      result.last_code   <= status.last_sym;
    end
  end

`include "huffman_code_builder_assert.svh"

  `HCB_ASSERT_NEXT(a_emit_strobe, cmd.emit, strobe, "emitted code missing strobe")
  `HCB_ASSERT_SAME(a_scan_in_range, cmd.scan, scan_idx < k, "scan past newest node")
  `HCB_ASSERT_SAME(a_merge_pair, cmd.merge, best_vld && sec_vld && (best_idx != sec_idx), "merge without two distinct nodes")

endmodule

// ===== sv/huffman_code_builder.sv =====
// ----------------------------------------------------------------------------
// huffman_code_builder
// Loads one weight per cycle while idle (busy low); a beat with load_last
// builds the tree, each of the N-1 merges following a scan over every node
// built so far. Each symbol's code is then walked from its leaf to the root;
// its result strobe, registered from the emit, cannot be stalled.
// busy stays high until the final code.
// Synchronous reset clears the weight store and returns to idle.
// ----------------------------------------------------------------------------
module huffman_code_builder #(
  parameter int NUM_SYMBOLS = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  hcb_pkg::item_t   item,
  output logic             strobe,
  output hcb_pkg::result_t result
);
  import hcb_pkg::*;

  cmd_t    cmd;
  status_t status;

  hcb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .load_last (item.load_last),
    .busy      (busy),
    .cmd       (cmd),
    .status    (status)
  );

  hcb_datapath #(
    .NUM_SYMBOLS (NUM_SYMBOLS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .status (status),
    .strobe (strobe),
    .result (result)
  );

endmodule

// ===== tb/tb_huffman_code_builder.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_huffman_code_builder
// Feeds weight sets to the Huffman code builder and checks every emitted
// code beat against a local tree builder that uses the same merge and
// tie-break order. Directed sets cover extreme, zero, repeated and ignored
// symbols; random sets vary weight spread, ordering and gaps.
// ----------------------------------------------------------------------------
module tb_huffman_code_builder;
  import hcb_pkg::*;

  localparam int NUM_SYM   = 6;
  localparam int NUM_NODE  = 2 * NUM_SYM - 1;
  localparam int ROOT      = NUM_NODE - 1;
  localparam int RAND_LOADS = 320;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  item_t   item = '0;
  logic    strobe;
  result_t result;

  huffman_code_builder #(.NUM_SYMBOLS(NUM_SYM)) u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .strobe (strobe),
    .result (result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  item_t              pending_loads[$];
  result_t            expected_codes[$];
  logic [WEIGHT_W-1:0] symbol_weight[NUM_SYM];
  int                 fail_cnt = 0;
  int                 idle_left = 0;
  int                 steady_left = 0;
  int                 load_cnt = 0;
  result_t            want;

  initial begin
    for (int i = 0; i < NUM_SYM; i++) symbol_weight[i] = '0;
  end

  // merge two lightest live nodes, lowest index wins ties; leaves are 0..N-1
  task automatic build_expected_codes();
    logic [NODE_W-1:0] w[NUM_NODE];
    bit                live[NUM_NODE];
    int                parent[NUM_NODE];
    bit                side[NUM_NODE];
    int                a, b, n, len;
    logic [CODE_W-1:0] code;
    result_t           r;
    for (int i = 0; i < NUM_NODE; i++) begin
      w[i] = '0;
      live[i] = 0;
      parent[i] = 0;
      side[i] = 0;
    end
    for (int i = 0; i < NUM_SYM; i++) begin
      w[i] = symbol_weight[i];
      live[i] = 1;
    end
    for (int k = NUM_SYM; k < NUM_NODE; k++) begin
      a = -1;
      for (int i = 0; i < k; i++)
        if (live[i] && (a < 0 || w[i] < w[a])) a = i;
      live[a] = 0;
      b = -1;
      for (int i = 0; i < k; i++)
        if (live[i] && (b < 0 || w[i] < w[b])) b = i;
      live[b] = 0;
      parent[a] = k;
      side[a] = 0;
      parent[b] = k;
      side[b] = 1;
      w[k] = w[a] + w[b];
      live[k] = 1;
    end
    for (int s = 0; s < NUM_SYM; s++) begin
      code = '0;
      len = 0;
      n = s;
      while (n != ROOT) begin
        code[len] = side[n];
        len++;
        n = parent[n];
      end
      r.out_symbol  = SYM_FLD_W'(s);
      r.code_bits   = code;
      r.code_length = CODE_LEN_W'(len);
      r.last_code   = (s == NUM_SYM - 1);
      expected_codes.push_back(r);
    end
    for (int i = 0; i < NUM_SYM; i++) symbol_weight[i] = '0;
  endtask

  task automatic absorb_load(input item_t it);
    if (it.symbol < NUM_SYM) symbol_weight[it.symbol] = it.weight;
    if (it.load_last) build_expected_codes();
  endtask

  function automatic int next_gap();
    int r;
    if (steady_left > 0) begin
      steady_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      steady_left = $urandom_range(10, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // driver: hold start with the head beat until start && !busy at an edge
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      idle_left = 0;
    end else begin
      if (start && !busy) begin
        absorb_load(item);
        void'(pending_loads.pop_front());
        idle_left = next_gap();
      end
      if (!start || !busy) begin
        if (idle_left > 0) begin
          idle_left--;
          start <= 1'b0;
        end else if (pending_loads.size() > 0) begin
          start <= 1'b1;
          item  <= pending_loads[0];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string fld, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", fld, want_v, got_v);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (expected_codes.size() == 0) begin
        $error("code beat with nothing expected: symbol %0d", result.out_symbol);
        fail_cnt++;
      end else begin
        want = expected_codes.pop_front();
        check_field("out_symbol", want.out_symbol, result.out_symbol);
        check_field("code_bits", want.code_bits, result.code_bits);
        check_field("code_length", want.code_length, result.code_length);
        check_field("last_code", want.last_code, result.last_code);
      end
    end
  end

  task automatic add_load(input int sym, input int wt, input bit last);
    item_t it;
    it.symbol    = SYM_FLD_W'(sym);
    it.weight    = WEIGHT_W'(wt);
    it.load_last = last;
    pending_loads.push_back(it);
    if (sym < NUM_SYM || last) load_cnt++;
  endtask

  function automatic int pick_weight(input int spread);
    case (spread)
      0: return $urandom_range(0, 65535);
      1: return $urandom_range(0, 3);
      2: return (1 << $urandom_range(0, 15)) + $urandom_range(0, 1);
      default: return $urandom_range(0, 1) ? 65535 : $urandom_range(0, 1);
    endcase
  endfunction

  task automatic add_random_set();
    int order[NUM_SYM];
    int spread, j, tmp;
    bit broken;
    spread = $urandom_range(0, 3);
    broken = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < NUM_SYM; i++) order[i] = i;
    for (int i = NUM_SYM - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < NUM_SYM - 1; i++) begin
      if ($urandom_range(0, 9) == 0)
        add_load($urandom_range(0, 7), $urandom_range(0, 65535), 1'b0);
      if (!(broken && $urandom_range(0, 2) == 0))
        add_load(order[i], pick_weight(spread), 1'b0);
    end
    if ($urandom_range(0, 7) == 0) begin
      add_load(order[NUM_SYM-1], pick_weight(spread), 1'b0);
      add_load($urandom_range(NUM_SYM, 7), $urandom_range(0, 65535), 1'b1);
    end else begin
      add_load(order[NUM_SYM-1], pick_weight(spread), 1'b1);
    end
  endtask

  initial begin
    // empty set closed by an ignored symbol
    add_load(7, 65535, 1'b1);
    // all weights at maximum
    for (int s = 0; s < NUM_SYM; s++) add_load(s, 65535, s == NUM_SYM - 1);
    // doubling weights give the deepest tree
    for (int s = 0; s < NUM_SYM; s++) add_load(s, 16 >> s, 1'b0);
    add_load(NUM_SYM - 1, 1, 1'b1);
    // overwrite, ignored symbol, zero weights
    add_load(2, 100, 1'b0);
    add_load(2, 5, 1'b0);
    add_load(6, 9, 1'b0);
    add_load(0, 0, 1'b0);
    add_load(1, 0, 1'b0);
    add_load(3, 65535, 1'b0);
    add_load(4, 7, 1'b0);
    add_load(5, 3, 1'b1);
    load_cnt = 0;
    while (load_cnt < RAND_LOADS) add_random_set();

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (pending_loads.size() > 0 || start || expected_codes.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("** huffman_code_builder: PASSED **");
    end else begin
      $display("** huffman_code_builder: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("** huffman_code_builder: FAILED **");
    $finish;
  end

endmodule
